/* design/rgbhsi_pkg.sv */
package rgbhsi_pkg;

	localparam int CB = 8;
	localparam int SW = CB + 2;
	localparam int NW = SW + 8;
	localparam int XW = CB + 21;
	localparam int ZW = 25;
	localparam int TW = 25;
	localparam int CORDIC_STAGES = 8;

	localparam int SQRT3_Q16 = 113512;
	localparam int DIV3_SH = SW + 1;
	localparam int DIV3_K = (2 ** DIV3_SH + 2) / 3;

	localparam int DEG90 = 90 * 65536;
	localparam int DEG180 = 180 * 65536;
	localparam int DEG360 = 360 * 65536;

	localparam int HUE_MUL = 17;
	localparam int HUE_SH = 19;
	localparam int HUE_T_W = 10;
	localparam int HDIV_K = 683;
	localparam int HDIV_SH = 11;

	typedef struct packed {
		logic gray;
		logic flip;
		logic gblt;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [NW-1:0] rem;
		logic [SW-1:0] sum;
		logic [7:0] quo;
		logic [CB-1:0] inten;
	} cst_t;

	function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			4'd0: a = ZW'(2949120);
			4'd1: a = ZW'(1740967);
			4'd2: a = ZW'(919879);
			4'd3: a = ZW'(466945);
			4'd4: a = ZW'(234379);
			4'd5: a = ZW'(117304);
			4'd6: a = ZW'(58666);
			4'd7: a = ZW'(29335);
			4'd8: a = ZW'(14668);
			4'd9: a = ZW'(7334);
			4'd10: a = ZW'(3667);
			4'd11: a = ZW'(1833);
			4'd12: a = ZW'(917);
			4'd13: a = ZW'(458);
			4'd14: a = ZW'(229);
			4'd15: a = ZW'(115);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

/* design/rgbhsi_front.sv */
module rgbhsi_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  logic [rgbhsi_pkg::CB-1:0] red,
	input  logic [rgbhsi_pkg::CB-1:0] green,
	input  logic [rgbhsi_pkg::CB-1:0] blue,
	output logic out_v,
	output rgbhsi_pkg::cst_t d_s1
);

	localparam int SW = rgbhsi_pkg::SW;
	localparam int NW = rgbhsi_pkg::NW;
	localparam int XW = rgbhsi_pkg::XW;
	localparam int CB = rgbhsi_pkg::CB;

	logic [SW-1:0] sum, mn, dd;
	logic [SW:0] xd;
	logic [SW-1:0] xa;
	logic [CB-1:0] gbd;
	logic [CB+16:0] yp;
	logic [2*SW+1:0] ip;
	rgbhsi_pkg::cst_t nx;

	always_comb begin
		sum = SW'(red) + SW'(green) + SW'(blue);
		if (red < green)
			mn = (red < blue) ? SW'(red) : SW'(blue);
		else
			mn = (green < blue) ? SW'(green) : SW'(blue);
		dd = sum - SW'(3 * mn);
		xd = ((SW+1)'(red) << 1) - (SW+1)'(green) - (SW+1)'(blue);
		xa = xd[SW] ? SW'(-xd) : xd[SW-1:0];
		gbd = (green > blue) ? (green - blue) : (blue - green);
		yp = (CB+17)'(gbd) * (CB+17)'(rgbhsi_pkg::SQRT3_Q16);
		ip = (2*SW+2)'(sum) * (2*SW+2)'(rgbhsi_pkg::DIV3_K);
		nx.gray = (red == green) && (green == blue);
		nx.flip = xd[SW];
		nx.gblt = green < blue;
		nx.x = XW'(xa) << 16;
		nx.y = XW'(yp);
		nx.z = '0;
		nx.rem = (NW'(dd) << 8) - NW'(dd);
		nx.sum = sum;
		nx.quo = '0;
		nx.inten = ip[rgbhsi_pkg::DIV3_SH +: CB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nx;
		end
	end

endmodule

/* design/rgbhsi_cordic.sv */
module rgbhsi_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  logic [2:0] idx,
	input  rgbhsi_pkg::cst_t d,
	output logic out_v,
	output rgbhsi_pkg::cst_t d_s
);

	localparam int XW = rgbhsi_pkg::XW;
	localparam int ZW = rgbhsi_pkg::ZW;
	localparam int NW = rgbhsi_pkg::NW;

	rgbhsi_pkg::cst_t nx;
	logic signed [XW-1:0] xt, yt, dx, dy;
	logic signed [ZW-1:0] zt;
	logic [3:0] it;
	logic [NW-1:0] dsh;

	// two micro-rotations plus one quotient bit per stage
	always_comb begin
		nx = d;
		xt = d.x;
		yt = d.y;
		zt = d.z;
		it = '0;
		dx = '0;
		dy = '0;
		for (int j = 0; j < 2; j++) begin
			it = {idx, j[0]};
			dx = yt >>> it;
			dy = xt >>> it;
			if (!yt[XW-1]) begin
				xt = xt + dx;
				yt = yt - dy;
				zt = zt + rgbhsi_pkg::atan_q16(it);
			end else begin
				xt = xt - dx;
				yt = yt + dy;
				zt = zt - rgbhsi_pkg::atan_q16(it);
			end
		end
		nx.x = xt;
		nx.y = yt;
		nx.z = zt;
		dsh = NW'(d.sum) << (3'd7 - idx);
		if (d.rem >= dsh) begin
			nx.rem = d.rem - dsh;
			nx.quo = {d.quo[6:0], 1'b1};
		end else begin
			nx.quo = {d.quo[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s <= nx;
		end
	end

endmodule

/* design/rgbhsi_back.sv */
module rgbhsi_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [2:0] en,
	input  logic in_v,
	input  rgbhsi_pkg::cst_t d,
	output logic [2:0] out_v,
	output logic [7:0] hue,
	output logic [7:0] saturation,
	output logic [rgbhsi_pkg::CB-1:0] intensity
);

	localparam int ZW = rgbhsi_pkg::ZW;
	localparam int TW = rgbhsi_pkg::TW;
	localparam int CB = rgbhsi_pkg::CB;
	localparam int HTW = rgbhsi_pkg::HUE_T_W;

	logic [TW-1:0] zc, th;
	logic [29:0] tp;
	logic [19:0] hp;

	logic [TW-1:0] th_s10;
	logic gray_s10, gray_s11, gray_s12;
	logic [7:0] sat_s10, sat_s11, sat_s12;
	logic [CB-1:0] int_s10, int_s11, int_s12;
	logic [HTW-1:0] t_s11;
	logic [7:0] hue_s12;

	always_comb begin
		if (d.z[ZW-1])
			zc = '0;
		else if (d.z > ZW'(rgbhsi_pkg::DEG90))
			zc = TW'(rgbhsi_pkg::DEG90);
		else
			zc = TW'(d.z);
		th = d.flip ? (TW'(rgbhsi_pkg::DEG180) - zc) : zc;
		if (d.gblt)
			th = TW'(rgbhsi_pkg::DEG360) - th;
		if (th >= TW'(rgbhsi_pkg::DEG360))
			th = th - TW'(rgbhsi_pkg::DEG360);
		tp = 30'(th_s10) * 30'(rgbhsi_pkg::HUE_MUL);
		hp = 20'(t_s11) * 20'(rgbhsi_pkg::HDIV_K);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= '0;
		end else begin
			if (en[0]) out_v[0] <= in_v;
			if (en[1]) out_v[1] <= out_v[0];
			if (en[2]) out_v[2] <= out_v[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			th_s10 <= th;
			gray_s10 <= d.gray;
			sat_s10 <= d.quo;
			int_s10 <= d.inten;
		end
		if (en[1]) begin
			t_s11 <= tp[rgbhsi_pkg::HUE_SH +: HTW];
			gray_s11 <= gray_s10;
			sat_s11 <= sat_s10;
			int_s11 <= int_s10;
		end
		if (en[2]) begin
			hue_s12 <= gray_s11 ? 8'd0 : hp[rgbhsi_pkg::HDIV_SH +: 8];
			gray_s12 <= gray_s11;
			sat_s12 <= sat_s11;
			int_s12 <= int_s11;
		end
	end

	assign hue = hue_s12;
	assign saturation = gray_s12 ? 8'd0 : sat_s12;
	assign intensity = int_s12;

endmodule

/* design/rgb_to_hsi_pixel.sv */
// channel   handshake                payload
// pixel     pix_valid / pix_stall    red, green, blue
// hsi       hsi_valid / hsi_stall    hue, saturation, intensity
//
// twelve register stages: one front stage, eight cordic stages with two
// micro-rotations and one saturation quotient bit each, three hue stages
// one word per clock when hsi_stall stays low
// arst_n clears all stage valid bits
// a stalled output holds; empty stages still fill behind it

module rgb_to_hsi_pixel (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_stall,
	input  logic [rgbhsi_pkg::CB-1:0] red,
	input  logic [rgbhsi_pkg::CB-1:0] green,
	input  logic [rgbhsi_pkg::CB-1:0] blue,
	output logic hsi_valid,
	input  logic hsi_stall,
	output logic [7:0] hue,
	output logic [7:0] saturation,
	output logic [rgbhsi_pkg::CB-1:0] intensity
);

	localparam int NS = rgbhsi_pkg::CORDIC_STAGES + 4;

	logic [NS-1:0] vld, en;
	rgbhsi_pkg::cst_t cs [0:rgbhsi_pkg::CORDIC_STAGES];

	always_comb begin
		en[NS-1] = !vld[NS-1] || !hsi_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign pix_stall = !en[0];

	rgbhsi_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en[0]), .in_v(pix_valid),
		.red(red), .green(green), .blue(blue),
		.out_v(vld[0]), .d_s1(cs[0])
	);

	for (genvar k = 0; k < rgbhsi_pkg::CORDIC_STAGES; k++) begin : g_cordic
		rgbhsi_cordic u_stage (
			.clk(clk), .arst_n(arst_n), .en(en[k+1]), .in_v(vld[k]),
			.idx(3'(k)), .d(cs[k]), .out_v(vld[k+1]), .d_s(cs[k+1])
		);
	end

	rgbhsi_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en[NS-1:NS-3]),
		.in_v(vld[NS-4]), .d(cs[rgbhsi_pkg::CORDIC_STAGES]),
		.out_v(vld[NS-1:NS-3]), .hue(hue), .saturation(saturation),
		.intensity(intensity)
	);

	assign hsi_valid = vld[NS-1];

endmodule

/* design/rgbhsi_chk.sv */
module rgbhsi_chk (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	input logic pix_stall,
	input logic hsi_valid,
	input logic hsi_stall,
	input logic [7:0] hue,
	input logic [7:0] saturation
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !hsi_valid)
		else $error("output word valid after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsi_valid && hsi_stall |=> hsi_valid && $stable(hue) && $stable(saturation))
		else $error("stalled output word changed");

	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> hsi_valid && hsi_stall)
		else $error("input stalled while output side can move");

	a_flow_through: assert property (@(posedge clk) disable iff (!arst_n)
		hsi_valid && !hsi_stall |-> !pix_stall)
		else $error("input stalled while output word moves");

endmodule

bind rgb_to_hsi_pixel rgbhsi_chk u_chk (
	.clk(clk), .arst_n(arst_n), .pix_valid(pix_valid), .pix_stall(pix_stall),
	.hsi_valid(hsi_valid), .hsi_stall(hsi_stall), .hue(hue),
	.saturation(saturation)
);

/* tb/sv/tb_rgb_to_hsi_pixel.sv */
module tb_rgb_to_hsi_pixel;
	import rgbhsi_pkg::*;

	localparam int RANDOM_WORDS = 1530;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [CB-1:0] r;
		logic [CB-1:0] g;
		logic [CB-1:0] b;
		bit known;
		logic [7:0] h;
		logic [7:0] s;
		logic [CB-1:0] i;
	} pixel_row_t;

	typedef struct {
		logic [7:0] h;
		logic [7:0] s;
		logic [CB-1:0] i;
	} hsi_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	logic [CB-1:0] red = '0;
	logic [CB-1:0] green = '0;
	logic [CB-1:0] blue = '0;
	logic hsi_valid;
	logic hsi_stall = 1'b0;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [CB-1:0] intensity;

	hsi_word_t hsi_pending[$];
	int fail_count = 0;
	int idle_cycles = 0;
	int out_wait = 0;

	rgb_to_hsi_pixel u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.hsi_valid(hsi_valid),
		.hsi_stall(hsi_stall),
		.hue(hue),
		.saturation(saturation),
		.intensity(intensity)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint floor_shift(longint v, int s);
		return (v >= 0) ? (v >>> s) : ~((~v) >>> s);
	endfunction

	function automatic hsi_word_t hsi_of_pixel(logic [CB-1:0] r8, logic [CB-1:0] g8,
			logic [CB-1:0] b8);
		hsi_word_t w;
		longint r, g, b, sum, mn, x, y, z, dx, dy, theta;
		bit flip;
		r = r8;
		g = g8;
		b = b8;
		sum = r + g + b;
		w.h = '0;
		w.s = '0;
		w.i = CB'(sum / 3);
		if (!(r == g && g == b)) begin
			mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
			x = (2 * r - g - b) * 65536;
			y = ((g > b) ? (g - b) : (b - g)) * 113512;
			flip = x < 0;
			if (sum > 0)
				w.s = 8'((255 * (sum - 3 * mn)) / sum);
			if (flip)
				x = -x;
			z = 0;
			for (int k = 0; k < 16; k++) begin
				dx = floor_shift(y, k);
				dy = floor_shift(x, k);
				if (y >= 0) begin
					x = x + dx;
					y = y - dy;
					z = z + atan_q16(4'(k));
				end else begin
					x = x - dx;
					y = y + dy;
					z = z - atan_q16(4'(k));
				end
			end
			if (z < 0)
				z = 0;
			if (z > DEG90)
				z = DEG90;
			theta = z;
			if (flip)
				theta = DEG180 - theta;
			if (g < b)
				theta = DEG360 - theta;
			if (theta >= DEG360)
				theta -= DEG360;
			w.h = 8'((theta * 255) / DEG360);
		end
		return w;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		fail_count++;
	endtask

	task automatic send_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b,
			hsi_word_t w);
		int gap;
		gap = $urandom_range(0, 4);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (pix_stall);
		hsi_pending.push_back(w);
	endtask

	// receiver stalls and checking
	always @(posedge clk) begin
		hsi_word_t w;
		if (arst_n) begin
			if (hsi_valid && !hsi_stall) begin
				if (hsi_pending.size() == 0) begin
					$display("unexpected word: hue %0d", hue);
					fail_count++;
				end else begin
					w = hsi_pending.pop_front();
					if (hue !== w.h)
						report_mismatch("hue", hue, w.h);
					if (saturation !== w.s)
						report_mismatch("saturation", saturation, w.s);
					if (intensity !== w.i)
						report_mismatch("intensity", intensity, w.i);
				end
				out_wait = $urandom_range(0, 4);
			end else if (hsi_valid && out_wait > 0) begin
				out_wait--;
			end
			if ((pix_valid && !pix_stall) || (hsi_valid && !hsi_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
			hsi_stall <= (out_wait != 0);
		end
	end

	initial begin
		pixel_row_t rows[20];
		pixel_row_t p;
		hsi_word_t w;
		int n;
		rows = '{
			'{8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0},
			'{8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd255},
			'{8'd128, 8'd128, 8'd128, 1'b1, 8'd0, 8'd0, 8'd128},
			'{8'd255, 8'd0, 8'd0, 1'b1, 8'd0, 8'd255, 8'd85},
			'{8'd0, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd0, 8'd0, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd255, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd0, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd255, 8'd0, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd0, 8'd128, 8'd128, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd200, 8'd10, 8'd10, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd1, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd0, 8'd0, 8'd1, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd0, 8'd1, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd255, 8'd254, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd255, 8'd1, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd255, 8'd0, 8'd1, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd170, 8'd85, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd85, 8'd170, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
			'{8'd100, 8'd50, 8'd150, 1'b0, 8'd0, 8'd0, 8'd0}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[k]) begin
			p = rows[k];
			if (p.known) begin
				w.h = p.h;
				w.s = p.s;
				w.i = p.i;
			end else
				w = hsi_of_pixel(p.r, p.g, p.b);
			send_pixel(p.r, p.g, p.b, w);
		end
		for (n = 0; n < RANDOM_WORDS; n++) begin
			case ($urandom_range(0, 5))
				0: begin
					p.r = CB'($urandom);
					p.g = p.r;
					p.b = p.r;
				end
				1: begin
					p.r = CB'($urandom);
					p.g = CB'($urandom);
					p.b = p.g;
				end
				2: begin
					p.r = CB'($urandom);
					p.g = p.r + CB'($urandom_range(0, 2)) - CB'(1);
					p.b = p.r + CB'($urandom_range(0, 2)) - CB'(1);
				end
				default: begin
					p.r = CB'($urandom);
					p.g = CB'($urandom);
					p.b = CB'($urandom);
				end
			endcase
			send_pixel(p.r, p.g, p.b, hsi_of_pixel(p.r, p.g, p.b));
		end
		pix_valid <= 1'b0;
		while (hsi_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
design/rgbhsi_pkg.sv
design/rgbhsi_front.sv
design/rgbhsi_cordic.sv
design/rgbhsi_back.sv
design/rgb_to_hsi_pixel.sv
design/rgbhsi_chk.sv
tb/sv/tb_rgb_to_hsi_pixel.sv
